// File: rtl/core/scene_cut_keyframe_decider_assert.svh
// Assertion macros shared by the frame decision logic.
`ifndef SCENE_CUT_KEYFRAME_DECIDER_ASSERT_SVH
`define SCENE_CUT_KEYFRAME_DECIDER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCKD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scene cut decider: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SCKD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scene cut decider: next-cycle check failed");

`endif

// File: rtl/core/sckd_pkg.sv
package sckd_pkg;

    // Frame store geometry.
    localparam int MAX_PIXELS = 65536;
    localparam int ADDR_W     = $clog2(MAX_PIXELS);
    localparam int PIX_W      = $clog2(MAX_PIXELS + 1);

    // Forced keyframe period in frames.
    localparam int KEY_PERIOD = 30;
    localparam int PERIOD_W   = $clog2(KEY_PERIOD + 1);

    // Field widths.
    localparam int SAMPLE_W  = 8;
    localparam int SUM_W     = 24;
    localparam int FRAME_W   = 32;
    localparam int QUAL_W    = 7;
    localparam int REQ_W     = 8;
    localparam int THR_W     = 16;
    localparam int LUMA_PIX_W = 17;
    localparam int PROD_W    = THR_W + PIX_W;
    localparam int CMP_W     = (SUM_W + 8 > PROD_W) ? SUM_W + 8 : PROD_W;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    // Quality limits and reset value.
    localparam logic [QUAL_W-1:0] QUALITY_MIN   = QUAL_W'(5);
    localparam logic [QUAL_W-1:0] QUALITY_MAX   = QUAL_W'(100);
    localparam logic [QUAL_W-1:0] QUALITY_RESET = QUAL_W'(50);

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = LUMA_PIX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUALITY     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LUMA_PIXELS = 2'd2;

    // Result packing.
    localparam int OUT_FIELDS_W = 3 + FRAME_W + QUAL_W + SUM_W;
    localparam int OUT_W        = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Clamp a requested quality to the supported range.
    function automatic logic [QUAL_W-1:0] limit_quality(input logic [REQ_W-1:0] req);
        logic [QUAL_W-1:0] q;
        if (req < REQ_W'(QUALITY_MIN)) begin
            q = QUALITY_MIN;
        end
        else if (req > REQ_W'(QUALITY_MAX)) begin
            q = QUALITY_MAX;
        end
        else begin
            q = req[QUAL_W-1:0];
        end
        return q;
    endfunction

    // Effective frame length: zero acts as one, large values are capped.
    function automatic logic [PIX_W-1:0] frame_length(input logic [LUMA_PIX_W-1:0] lp);
        logic [PIX_W-1:0] n;
        if (lp == '0) begin
            n = PIX_W'(1);
        end
        else if (32'(lp) > 32'(MAX_PIXELS)) begin
            n = PIX_W'(MAX_PIXELS);
        end
        else begin
            n = PIX_W'(lp);
        end
        return n;
    endfunction

endpackage

// File: rtl/core/sckd_ram.sv
module sckd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read; a read of the address being written
    // returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/scene_cut_keyframe_decider.sv
// Results: once a frame's last luma sample is accepted into stage 1, its result is loaded
// into the output register when stage 1 advances.
// Throughput: one luma sample per cycle; the store is read and written at the same address
// in the accept cycle and the difference is summed in stage 1. The input stalls only
// while a finished frame waits behind an output that is full and not ready.
// Reset clears control state, counters and configuration registers; the store is not cleared.
`include "scene_cut_keyframe_decider_assert.svh"

module scene_cut_keyframe_decider
    import sckd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Luma samples in.
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // [7:0] luma_sample
    // Frame decisions out.
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_W-1:0]      m_axis_tdata,   // [0] keyframe flag, [1] cut flag,
                                                  // [2] quality change flag,
                                                  // [34:3] frame_number,
                                                  // [41:35] quality_in_use,
                                                  // [65:42] difference_sum, rest zero
    // Configuration writes.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                first;
        logic                last;
        logic [PROD_W-1:0]   prod;
        logic [FRAME_W-1:0]  frame;
        logic [QUAL_W-1:0]   quality;
        logic                changed;
        logic                periodic;
    } stage_t;

    // Configuration registers.
    logic [THR_W-1:0]      thr_reg;
    logic [REQ_W-1:0]      req_q_reg;
    logic [LUMA_PIX_W-1:0] luma_pix_reg;

    // Frame state.
    logic [PIX_W-1:0]    pc_reg, pc_next;
    logic [FRAME_W-1:0]  frame_reg;
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [QUAL_W-1:0]   quality_reg;
    logic [SUM_W-1:0]    sum_reg;

    // Pipeline and output registers.
    logic              s1_valid_reg;
    stage_t            s1_reg, s1_next;
    logic              out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]  out_data_reg, out_data_next;

    logic                s_accept;
    logic                s1_advance;
    logic [PIX_W-1:0]    count;
    logic [ADDR_W-1:0]   pos;
    logic [PIX_W-1:0]    pos_inc;
    logic                s0_end;
    logic [QUAL_W-1:0]   req_clamped;
    logic [PERIOD_W:0]   period_inc;
    logic [SAMPLE_W-1:0] old_sample;
    logic [SAMPLE_W-1:0] diff;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_acc;
    logic                cut;
    logic                key;

    assign cfg_ready = 1'b1;

    // Configuration write decode; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg      <= '0;
            req_q_reg    <= REQ_W'(QUALITY_RESET);
            luma_pix_reg <= LUMA_PIX_W'(MAX_PIXELS);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD:   thr_reg      <= cfg_data[THR_W-1:0];
                CFG_QUALITY:     req_q_reg    <= cfg_data[REQ_W-1:0];
                CFG_LUMA_PIXELS: luma_pix_reg <= cfg_data[LUMA_PIX_W-1:0];
                default:         ;
            endcase
        end
    end

    // Stage 1 moves on unless it holds a frame result and the output is full and not ready.
    assign s1_advance    = !s1_valid_reg || !s1_reg.last || !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Stage 0: position, end of frame and per-frame decisions.
    assign count       = frame_length(luma_pix_reg);
    assign pos         = (32'(pc_reg) >= 32'(MAX_PIXELS)) ? ADDR_W'(MAX_PIXELS - 1)
                                                          : pc_reg[ADDR_W-1:0];
    assign pos_inc     = PIX_W'(pos) + PIX_W'(1);
    assign s0_end      = pos_inc >= count;
    assign req_clamped = limit_quality(req_q_reg);
    assign period_inc  = (PERIOD_W + 1)'(period_reg) + (PERIOD_W + 1)'(1);

    always_comb
    begin
        s1_next.sample   = s_axis_tdata[SAMPLE_W-1:0];
        s1_next.first    = (frame_reg == '0);
        s1_next.last     = s0_end;
        s1_next.prod     = PROD_W'(thr_reg) * PROD_W'(count);
        s1_next.frame    = frame_reg;
        s1_next.quality  = req_clamped;
        s1_next.changed  = (req_clamped != quality_reg);
        s1_next.periodic = (period_reg == '0);

        pc_next = s0_end ? '0 : pos_inc;
        if (32'(period_inc) >= 32'(KEY_PERIOD))
        begin
            period_next = '0;
        end
        else
        begin
            period_next = period_inc[PERIOD_W-1:0];
        end
    end

    // Previous frame store: read and replace the sample at the same position.
    sckd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_store (
        .clk     (clk),
        .wr_en   (s_accept),
        .wr_addr (pos),
        .wr_data (s_axis_tdata[SAMPLE_W-1:0]),
        .rd_en   (s_accept),
        .rd_addr (pos),
        .rd_data (old_sample)
    );

    // Stage 1: absolute difference, saturating sum and the frame decision.
    always_comb
    begin
        diff     = (s1_reg.sample > old_sample) ? s1_reg.sample - old_sample
                                                : old_sample - s1_reg.sample;
        sum_wide = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(diff);
        if (s1_reg.first)
        begin
            sum_acc = sum_reg;
        end
        else if (sum_wide[SUM_W])
        begin
            sum_acc = SUM_MAX;
        end
        else
        begin
            sum_acc = sum_wide[SUM_W-1:0];
        end
        cut = !s1_reg.first && (s1_reg.prod != '0) &&
              (CMP_W'({sum_acc, 8'b0}) >= CMP_W'(s1_reg.prod));
        key = s1_reg.first || cut || s1_reg.changed || s1_reg.periodic;
        out_data_next = OUT_W'({sum_acc, s1_reg.quality, s1_reg.frame,
                                s1_reg.changed, cut, key});
    end

    // The output holds a result until it is taken; a new one may load in the same cycle.
    assign out_valid_next = (s1_valid_reg && s1_advance && s1_reg.last) ||
                            (out_valid_reg && !m_axis_tready);

    // Frame counters and stage 0 state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= '0;
            frame_reg   <= '0;
            period_reg  <= '0;
            quality_reg <= QUALITY_RESET;
        end
        else if (s_accept)
        begin
            pc_reg <= pc_next;
            if (s0_end)
            begin
                frame_reg   <= frame_reg + FRAME_W'(1);
                period_reg  <= period_next;
                quality_reg <= req_clamped;
            end
        end
    end

    // Stage 1 valid, the running sum and the output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_valid_reg && s1_advance)
            begin
                if (s1_reg.last)
                begin
                    sum_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_acc;
                end
            end
            if (s1_advance)
            begin
                s1_valid_reg <= s_accept;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_reg <= s1_next;
        end
        if (s1_valid_reg && s1_advance && s1_reg.last)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // The pixel position never leaves the frame store.
    `SCKD_ASSERT_SAME(a_pc_in_store, 1'b1, 32'(pc_reg) < 32'(MAX_PIXELS))
    // The last sample of a frame restarts the position count.
    `SCKD_ASSERT_NEXT(a_pc_restart, s_accept && s0_end, pc_reg == '0)
    // Nothing is accumulated while the first frame is in flight.
    `SCKD_ASSERT_SAME(a_first_no_sum, s1_valid_reg && s1_reg.first, sum_reg == '0)
    // A first frame result is a keyframe with no scene cut and no difference.
    `SCKD_ASSERT_SAME(a_first_result,
        m_axis_tvalid && (m_axis_tdata[34:3] == '0),
        m_axis_tdata[0] && !m_axis_tdata[1] && (m_axis_tdata[65:42] == '0))

endmodule

// File: sim/sckd_checker.sv
`timescale 1ns / 1ps

module sckd_checker
    import sckd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,   // [7:0] luma_sample
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_W-1:0]      m_axis_tdata,   // [0] keyframe flag, [1] cut flag,
                                                  // [2] quality change flag,
                                                  // [34:3] frame_number,
                                                  // [41:35] quality_in_use,
                                                  // [65:42] difference_sum, rest zero
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  wrap_up,
    output int                    outstanding,
    output int                    failures,
    output int                    frames_checked
);

    // Bit positions of the result fields.
    localparam int FRAME_LSB = 3;
    localparam int QUAL_LSB  = FRAME_LSB + FRAME_W;
    localparam int SAD_LSB   = QUAL_LSB + QUAL_W;
    localparam int PAD_LSB   = SAD_LSB + SUM_W;

    typedef struct packed {
        logic                keyframe;
        logic                cut;
        logic                quality_moved;
        logic [FRAME_W-1:0]  frame_no;
        logic [QUAL_W-1:0]   quality;
        logic [SUM_W-1:0]    sad;
    } frame_verdict_t;

    // Shadow copy of the frame store, the running counters and the registers.
    logic [SAMPLE_W-1:0]   last_luma [MAX_PIXELS];
    logic [SUM_W-1:0]      sad_acc;
    logic [PIX_W-1:0]      luma_pos;
    logic [FRAME_W-1:0]    frame_idx;
    int                    period_pos;
    logic [QUAL_W-1:0]     quality_now;
    logic [THR_W-1:0]      cut_threshold;
    logic [REQ_W-1:0]      quality_req;
    logic [LUMA_PIX_W-1:0] frame_pixels;

    frame_verdict_t pending_verdicts [$];
    int             mismatches = 0;
    int             verdicts_seen = 0;
    bit             leftovers_flagged = 1'b0;

    function automatic logic [QUAL_W-1:0] bound_quality(input logic [REQ_W-1:0] req);
        if (req < REQ_W'(QUALITY_MIN)) return QUALITY_MIN;
        if (req > REQ_W'(QUALITY_MAX)) return QUALITY_MAX;
        return req[QUAL_W-1:0];
    endfunction

    // Zero behaves as a one-sample frame, anything past the store is capped.
    function automatic int effective_span(input logic [LUMA_PIX_W-1:0] lp);
        if (lp == '0) return 1;
        if (int'(lp) > MAX_PIXELS) return MAX_PIXELS;
        return int'(lp);
    endfunction

    task automatic report_mismatch(input string what, input logic [FRAME_W-1:0] frame,
                                   input logic [63:0] got, input logic [63:0] want);
        mismatches++;
        $display("checker: frame %0d %s: got 0x%0h, expected 0x%0h at %0t",
                 frame, what, got, want, $time);
    endtask

    task automatic latch_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_THRESHOLD:   cut_threshold = val[THR_W-1:0];
            CFG_QUALITY:     quality_req   = val[REQ_W-1:0];
            CFG_LUMA_PIXELS: frame_pixels  = val[LUMA_PIX_W-1:0];
            default: ;
        endcase
    endtask

    // Fold one sample into the store and the sum; close the frame when the count is met.
    task automatic absorb_luma(input logic [SAMPLE_W-1:0] luma);
        int                span;
        int                pos;
        logic              first;
        logic [SAMPLE_W:0] delta;
        logic [SUM_W:0]    widened;
        logic [63:0]       scaled_sum;
        logic [63:0]       scaled_thr;
        logic [QUAL_W-1:0] q;
        frame_verdict_t    v;
        span = effective_span(frame_pixels);
        pos = int'(luma_pos);
        if (pos >= MAX_PIXELS) pos = MAX_PIXELS - 1;
        first = (frame_idx == '0);
        if (!first) begin
            delta = (luma > last_luma[pos]) ? luma - last_luma[pos] : last_luma[pos] - luma;
            widened = {1'b0, sad_acc} + delta;
            sad_acc = (widened > {1'b0, SUM_MAX}) ? SUM_MAX : widened[SUM_W-1:0];
        end
        last_luma[pos] = luma;
        luma_pos = PIX_W'(pos + 1);
        if (int'(luma_pos) >= span) begin
            // Mean difference against the 8.8 threshold, done without division.
            scaled_sum = 64'(sad_acc) << 8;
            scaled_thr = 64'(cut_threshold) * 64'(span);
            v.cut = !first && (cut_threshold != '0) && (scaled_sum >= scaled_thr);
            q = bound_quality(quality_req);
            v.quality_moved = (q != quality_now);
            quality_now = q;
            v.keyframe = first || v.cut || v.quality_moved || (period_pos == 0);
            v.frame_no = frame_idx;
            v.quality = quality_now;
            v.sad = sad_acc;
            pending_verdicts.push_back(v);
            frame_idx = frame_idx + 1'b1;
            period_pos = (period_pos + 1 >= KEY_PERIOD) ? 0 : period_pos + 1;
            sad_acc = '0;
            luma_pos = '0;
        end
    endtask

    task automatic check_verdict(input logic [OUT_W-1:0] word);
        frame_verdict_t want;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("result with no frame pending", word[QUAL_LSB-1:FRAME_LSB],
                            64'(word[PAD_LSB-1:0]), '0);
            return;
        end
        want = pending_verdicts.pop_front();
        verdicts_seen++;
        if (word[0] !== want.keyframe)
            report_mismatch("keyframe flag", want.frame_no, 64'(word[0]), 64'(want.keyframe));
        if (word[1] !== want.cut)
            report_mismatch("cut flag", want.frame_no, 64'(word[1]), 64'(want.cut));
        if (word[2] !== want.quality_moved)
            report_mismatch("quality change flag", want.frame_no, 64'(word[2]),
                            64'(want.quality_moved));
        if (word[QUAL_LSB-1:FRAME_LSB] !== want.frame_no)
            report_mismatch("frame_number", want.frame_no,
                            64'(word[QUAL_LSB-1:FRAME_LSB]), 64'(want.frame_no));
        if (word[SAD_LSB-1:QUAL_LSB] !== want.quality)
            report_mismatch("quality_in_use", want.frame_no,
                            64'(word[SAD_LSB-1:QUAL_LSB]), 64'(want.quality));
        if (word[PAD_LSB-1:SAD_LSB] !== want.sad)
            report_mismatch("difference_sum", want.frame_no,
                            64'(word[PAD_LSB-1:SAD_LSB]), 64'(want.sad));
        if (word[OUT_W-1:PAD_LSB] !== '0)
            report_mismatch("padding bits", want.frame_no,
                            64'(word[OUT_W-1:PAD_LSB]), '0);
    endtask

    // All channels are sampled at the clock edge; the counts are registered outputs.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sad_acc = '0;
            luma_pos = '0;
            frame_idx = '0;
            period_pos = 0;
            quality_now = QUALITY_RESET;
            cut_threshold = '0;
            quality_req = REQ_W'(QUALITY_RESET);
            frame_pixels = LUMA_PIX_W'(MAX_PIXELS);
            pending_verdicts.delete();
            outstanding <= 0;
            failures <= 0;
            frames_checked <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) check_verdict(m_axis_tdata);
            if (cfg_valid && cfg_ready) latch_register(cfg_index, cfg_data);
            if (s_axis_tvalid && s_axis_tready) absorb_luma(s_axis_tdata);
            if (wrap_up && !leftovers_flagged) begin
                leftovers_flagged = 1'b1;
                if (pending_verdicts.size() != 0)
                    report_mismatch("frame results never delivered",
                                    pending_verdicts[0].frame_no,
                                    64'(pending_verdicts.size()), '0);
            end
            outstanding <= pending_verdicts.size();
            failures <= mismatches;
            frames_checked <= verdicts_seen;
        end
    end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
    import sckd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 400;
    localparam int SMALL_ITEMS   = 600;
    localparam int RANDOM_FRAMES = 40;
    localparam int MIRROR_DEPTH  = 64;

    typedef enum {FILL_RANDOM, FILL_NEAR} fill_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;   // [7:0] luma_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;   // [0] keyframe flag, [1] cut flag,
                                           // [2] quality change flag, [34:3] frame_number,
                                           // [41:35] quality_in_use,
                                           // [65:42] difference_sum, rest zero
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  wrap_up;
    int                    outstanding;
    int                    failures;
    int                    frames_checked;

    // Stimulus bookkeeping: where the sender stands inside the current frame.
    bit                    steady;
    bit                    bulk;
    int                    frame_len;
    int                    taken;
    bit                    frame_closed;
    int                    small_items;
    int                    frames_sent;
    int                    reg_writes;
    logic [SAMPLE_W-1:0]   luma_mirror [MIRROR_DEPTH];

    scene_cut_keyframe_decider uut (.*);

    sckd_checker decision_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic push_luma(input logic [SAMPLE_W-1:0] luma);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= luma;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        gap = idle_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic feed_luma(input logic [SAMPLE_W-1:0] luma);
        push_luma(luma);
        if (taken < MIRROR_DEPTH) luma_mirror[taken] = luma;
        taken++;
        if (!bulk) small_items++;
        frame_closed = (taken >= frame_len);
        if (frame_closed)
        begin
            taken = 0;
            frames_sent++;
        end
    endtask

    // A sample close to what the store holds at this position.
    function automatic logic [SAMPLE_W-1:0] near_luma(input int noise);
        int v;
        if (taken >= MIRROR_DEPTH) return SAMPLE_W'($urandom_range(0, 255));
        v = int'(luma_mirror[taken]) + int'($urandom_range(0, 2 * noise)) - noise;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return SAMPLE_W'(v);
    endfunction

    // A sample exactly delta away from the stored one.
    function automatic logic [SAMPLE_W-1:0] offset_luma(input int delta);
        int base;
        base = int'(luma_mirror[taken]);
        return SAMPLE_W'((base < 128) ? base + delta : base - delta);
    endfunction

    task automatic send_frame(input fill_t fill, input int noise);
        frame_closed = 1'b0;
        while (!frame_closed)
            feed_luma((fill == FILL_NEAR) ? near_luma(noise)
                                          : SAMPLE_W'($urandom_range(0, 255)));
    endtask

    // Part of a frame, never its last sample.
    task automatic send_part(input int count);
        repeat (count)
            if (taken + 1 < frame_len) feed_luma(SAMPLE_W'($urandom_range(0, 255)));
    endtask

    // Stop sending and wait until every frame decision is out.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        reg_writes++;
        if (idx == CFG_LUMA_PIXELS)
            frame_len = (val == '0) ? 1 : (int'(val) > MAX_PIXELS) ? MAX_PIXELS : int'(val);
    endtask

    task automatic write_random_reg();
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        int                    roll;
        idx = CFG_IDX_W'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        // Upper bits that the register drops are left noisy now and then.
        val = CFG_DATA_W'($urandom);
        case (idx)
            CFG_THRESHOLD:
            begin
                if (roll < 10) val[THR_W-1:0] = '0;
                else if (roll < 18) val[THR_W-1:0] = '1;
                else if (roll < 22) val[THR_W-1:0] = THR_W'(1);
                else val[THR_W-1:0] = THR_W'($urandom_range(1, 24 * 256));
                if (roll % 4 != 0) val[CFG_DATA_W-1:THR_W] = '0;
            end
            CFG_QUALITY:
            begin
                val[REQ_W-1:0] = (roll < 30) ? REQ_W'($urandom_range(0, 255))
                                             : REQ_W'($urandom_range(0, 110));
                if (roll % 4 != 0) val[CFG_DATA_W-1:REQ_W] = '0;
            end
            CFG_LUMA_PIXELS:
            begin
                if (roll < 4) val = '0;
                else if (roll < 8) val = CFG_DATA_W'(1);
                else if (roll < 18) val = CFG_DATA_W'($urandom_range(25, 64));
                else val = CFG_DATA_W'($urandom_range(2, 24));
            end
            default: ;
        endcase
        write_reg(idx, val);
    endtask

    task automatic probe_quality(input logic [REQ_W-1:0] req);
        settle();
        write_reg(CFG_QUALITY, CFG_DATA_W'(req));
        feed_luma(SAMPLE_W'($urandom_range(0, 255)));
    endtask

    // Result side: ready in bursts, with stalls unless the phase runs steady.
    initial
    begin
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            m_axis_tready <= 1'b1;
            repeat (1 + $urandom_range(0, 7)) @(posedge clk);
            stall = idle_len();
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Ends the run when no channel has moved an item for too long.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no item moved for %0d cycles", QUIET_LIMIT);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        fill_t fill;
        int    noise;
        int    base_frames;
        bit    big_done;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        wrap_up = 1'b0;
        steady = 1'b0;
        bulk = 1'b0;
        frame_len = MAX_PIXELS;
        taken = 0;
        frame_closed = 1'b0;
        small_items = 0;
        frames_sent = 0;
        reg_writes = 0;
        big_done = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // First frame writes every store entry that later frames read.
        steady = 1'b1;
        bulk = 1'b1;
        write_reg(CFG_LUMA_PIXELS, CFG_DATA_W'(MIRROR_DEPTH));
        send_frame(FILL_RANDOM, 0);
        bulk = 1'b0;
        steady = 1'b0;

        // One-sample frames right at the scene-cut boundary and at the extremes.
        settle();
        write_reg(CFG_LUMA_PIXELS, CFG_DATA_W'(1));
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(20 * 256));
        feed_luma(offset_luma(20));
        settle();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(20 * 256 + 1));
        feed_luma(offset_luma(20));
        settle();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(16'hFFFF));
        feed_luma('0);
        feed_luma('1);
        settle();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(16'hFF00));
        feed_luma('0);
        settle();
        write_reg(CFG_THRESHOLD, CFG_DATA_W'(17'h10000));
        feed_luma(SAMPLE_W'($urandom_range(0, 255)));

        // Requested quality below, at and above the clamp limits.
        probe_quality(8'd0);
        probe_quality(8'd4);
        probe_quality(8'd255);
        probe_quality(8'd101);
        probe_quality(8'd100);
        probe_quality(8'd5);
        probe_quality(8'd50);

        // A zero count, an unknown register, and a count above the store lowered mid-frame.
        settle();
        write_reg(CFG_LUMA_PIXELS, '0);
        feed_luma(SAMPLE_W'($urandom_range(0, 255)));
        settle();
        write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
        feed_luma(SAMPLE_W'($urandom_range(0, 255)));
        settle();
        write_reg(CFG_LUMA_PIXELS, '1);
        send_part(5);
        settle();
        write_reg(CFG_LUMA_PIXELS, CFG_DATA_W'(3));
        send_frame(FILL_RANDOM, 0);

        // Random phases of short frames, with register changes between and inside frames.
        small_items = 0;
        base_frames = frames_sent;
        while (small_items < SMALL_ITEMS || frames_sent - base_frames < RANDOM_FRAMES)
        begin
            settle();
            steady = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(0, 3)) write_random_reg();
            if (!big_done && frames_sent - base_frames >= RANDOM_FRAMES / 2)
            begin
                // One frame of the longest length in use, threshold near the random mean.
                write_reg(CFG_LUMA_PIXELS, CFG_DATA_W'(MIRROR_DEPTH));
                write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(21000, 22500)));
                steady = 1'b1;
                bulk = 1'b1;
                send_frame(FILL_RANDOM, 0);
                bulk = 1'b0;
                big_done = 1'b1;
                settle();
                write_reg(CFG_LUMA_PIXELS, CFG_DATA_W'($urandom_range(1, 24)));
            end
            repeat ($urandom_range(1, 4))
            begin
                fill = ($urandom_range(0, 2) == 0) ? FILL_RANDOM : FILL_NEAR;
                noise = $urandom_range(0, 24);
                if ($urandom_range(0, 4) == 0)
                begin
                    send_part($urandom_range(1, 8));
                    if (taken != 0)
                    begin
                        settle();
                        write_random_reg();
                    end
                end
                send_frame(fill, noise);
            end
        end

        settle();
        wrap_up <= 1'b1;
        repeat (2) @(posedge clk);
        $display("summary: %0d random samples, %0d frame decisions checked, %0d register writes",
                 small_items, frames_checked, reg_writes);
        $display("summary: store-filling first frame, boundary thresholds, clamped qualities");
        if (failures == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
